[hw/rtl/fphs_pkg.sv]
package fphs_pkg;

  localparam int FIELD_W = 16;
  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int ST_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOLE  = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADKIND = 2'd2,
    ST_NOFIT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } acc_ctl_t;

endpackage

[hw/rtl/fphs_in_if.sv]
interface fphs_in_if;
  import fphs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KIND_W-1:0]  entry_kind;
  logic [FIELD_W-1:0] entry_size;
  logic [FIELD_W-1:0] request_size;

  modport source (
    output valid, operation, entry_kind, entry_size, request_size,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_kind, entry_size, request_size,
    output ready
  );
endinterface

[hw/rtl/fphs_out_if.sv]
interface fphs_out_if;
  import fphs_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [FIELD_W-1:0] first_fit_size;
  logic [FIELD_W-1:0] best_fit_size;
  logic [FIELD_W-1:0] worst_fit_size;

  modport source (
    output valid, status, first_fit_size, best_fit_size, worst_fit_size,
    input  ready
  );

  modport sink (
    input  valid, status, first_fit_size, best_fit_size, worst_fit_size,
    output ready
  );
endinterface

[hw/rtl/fphs_region_table.sv]
module fphs_region_table #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 17,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  import fphs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/fphs_fit_accum.sv]
module fphs_fit_accum #(
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fphs_pkg::acc_ctl_t   ctl,
  input  logic [SIZE_BITS-1:0] req,
  input  logic                 ent_is_hole,
  input  logic [SIZE_BITS-1:0] ent_size,
  output logic                 found,
  output logic [SIZE_BITS-1:0] first_size,
  output logic [SIZE_BITS-1:0] best_size,
  output logic [SIZE_BITS-1:0] worst_size
);
  import fphs_pkg::*;

  logic                 found_r, found_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [SIZE_BITS-1:0] first_r, first_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [SIZE_BITS-1:0] worst_r, worst_nxt;
  logic                 fits;

  assign fits = ent_is_hole && (ent_size >= req_r);

  always_comb begin
    found_nxt = found_r;
    req_nxt   = req_r;
    first_nxt = first_r;
    best_nxt  = best_r;
    worst_nxt = worst_r;
    if (ctl.start) begin
      found_nxt = 1'b0;
      req_nxt   = req;
    end else if (ctl.step && fits) begin
      found_nxt = 1'b1;
      if (!found_r) begin
        first_nxt = ent_size;
        best_nxt  = ent_size;
        worst_nxt = ent_size;
      end else begin
        if (ent_size < best_r) begin
          best_nxt = ent_size;
        end
        if (ent_size > worst_r) begin
          worst_nxt = ent_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    first_r <= first_nxt;
    best_r  <= best_nxt;
    worst_r <= worst_nxt;
  end

  assign found      = found_r;
  assign first_size = first_r;
  assign best_size  = best_r;
  assign worst_size = worst_r;

endmodule

[hw/rtl/fit_policy_hole_search_unit.sv]
// Keeps an ordered table of up to MAX_ENTRIES regions (used blocks or free
// holes) and answers requests on it. Clear and append items load their
// result as they are taken; an append of a kind other than block or hole
// returns status 2, one to a full table returns status 1. A query walks
// the stored regions in order through one compare unit and returns the
// first, smallest and largest hole not smaller than the request, or status
// 3 with zero sizes when none fits. The single read port of the region
// table feeds the compare unit one region per cycle. A new item is taken
// once the previous result has left the output register or is leaving it.
// Sizes are held modulo 2^SIZE_BITS; no clearing pass follows reset.
module fit_policy_hole_search_unit #(
  parameter int MAX_ENTRIES = 32,
  parameter int SIZE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fphs_in_if.sink    in_ch,
  fphs_out_if.source out_ch
);
  import fphs_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WIDE_W = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;
  localparam int ENT_W  = SIZE_BITS + 1;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 dvld_r, dvld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]   out_first_r, out_first_nxt;
  logic [FIELD_W-1:0]   out_best_r, out_best_nxt;
  logic [FIELD_W-1:0]   out_worst_r, out_worst_nxt;

  logic                 in_fire;
  logic                 load;
  logic                 ld_from_acc;
  logic [ST_W-1:0]      ld_status;
  logic                 wr_en;
  logic                 rd_en;
  logic [ENT_W-1:0]     wr_data;
  logic [ENT_W-1:0]     rd_data;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 table_full;
  logic                 kind_ok;
  acc_ctl_t             acc_ctl;
  logic                 acc_found;
  logic [SIZE_BITS-1:0] acc_first, acc_best, acc_worst;
  logic [WIDE_W-1:0]    esize_wide, req_wide;
  logic [WIDE_W-1:0]    first_wide, best_wide, worst_wide;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  assign esize_wide = WIDE_W'(in_ch.entry_size);
  assign req_wide   = WIDE_W'(in_ch.request_size);
  assign first_wide = WIDE_W'(acc_first);
  assign best_wide  = WIDE_W'(acc_best);
  assign worst_wide = WIDE_W'(acc_worst);

  assign cnt_m1     = count_r - 1'b1;
  assign table_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign kind_ok    = (in_ch.entry_kind == KIND_BLOCK) || (in_ch.entry_kind == KIND_HOLE);
  assign wr_data    = {(in_ch.entry_kind == KIND_HOLE), esize_wide[SIZE_BITS-1:0]};

  fphs_region_table #(
    .DEPTH  (MAX_ENTRIES),
    .DATA_W (ENT_W),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  fphs_fit_accum #(
    .SIZE_BITS (SIZE_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .req         (req_wide[SIZE_BITS-1:0]),
    .ent_is_hole (rd_data[SIZE_BITS]),
    .ent_size    (rd_data[SIZE_BITS-1:0]),
    .found       (acc_found),
    .first_size  (acc_first),
    .best_size   (acc_best),
    .worst_size  (acc_worst)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.operation == OP_QUERY) && (count_r != '0)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == cnt_m1[IDX_W-1:0]) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    dvld_nxt      = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    acc_ctl.start = 1'b0;
    acc_ctl.step  = dvld_r;
    load          = 1'b0;
    ld_from_acc   = 1'b0;
    ld_status     = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          unique case (in_ch.operation)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (!kind_ok) begin
                ld_status = ST_BADKIND;
              end else if (table_full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                ld_status = ST_NOFIT;
              end else begin
                load          = 1'b0;
                acc_ctl.start = 1'b1;
                idx_nxt       = '0;
              end
            end
            default: begin
              ld_status = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_en    = 1'b1;
        dvld_nxt = 1'b1;
        idx_nxt  = idx_r + 1'b1;
      end
      S_DRAIN: begin
        dvld_nxt = 1'b0;
      end
      S_RESP: begin
        load        = 1'b1;
        ld_from_acc = acc_found;
        ld_status   = acc_found ? ST_OK : ST_NOFIT;
      end
      default: begin
        dvld_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_best_nxt   = out_best_r;
    out_worst_nxt  = out_worst_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ld_status;
      out_first_nxt  = ld_from_acc ? first_wide[FIELD_W-1:0] : '0;
      out_best_nxt   = ld_from_acc ? best_wide[FIELD_W-1:0] : '0;
      out_worst_nxt  = ld_from_acc ? worst_wide[FIELD_W-1:0] : '0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_best_r   <= out_best_nxt;
    out_worst_r  <= out_worst_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.first_fit_size = out_first_r;
  assign out_ch.best_fit_size  = out_best_r;
  assign out_ch.worst_fit_size = out_worst_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("region count beyond table depth");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dvld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("table read data outside scan");

  a_fit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && acc_found) |-> (acc_best <= acc_first && acc_first <= acc_worst))
    else $error("best, first and worst fit out of order");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import fphs_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int ITEM_TARGET = 1950;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 64;
  localparam longint TIMEOUT_NS = 3_000_000;

  typedef struct packed {
    status_t            st;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] best;
    logic [FIELD_W-1:0] worst;
  } fit_reply_t;

  class fit_scoreboard;
    logic               hole_flag [TABLE_DEPTH];
    logic [FIELD_W-1:0] region_sz [TABLE_DEPTH];
    int                 used;
    fit_reply_t         expected_fits[$];
    int                 errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void predict_fit(op_t op, logic [KIND_W-1:0] kind,
                              logic [FIELD_W-1:0] esz, logic [FIELD_W-1:0] req);
      fit_reply_t r;
      bit         found;
      r.st    = ST_OK;
      r.first = '0;
      r.best  = '0;
      r.worst = '0;
      found   = 1'b0;
      case (op)
        OP_CLEAR: used = 0;
        OP_APPEND: begin
          if (kind != KIND_BLOCK && kind != KIND_HOLE) begin
            r.st = ST_BADKIND;
          end else if (used >= TABLE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            hole_flag[used] = (kind == KIND_HOLE);
            region_sz[used] = esz;
            used++;
          end
        end
        OP_QUERY: begin
          for (int k = 0; k < used; k++) begin
            if (hole_flag[k] && region_sz[k] >= req) begin
              if (!found) begin
                found   = 1'b1;
                r.first = region_sz[k];
                r.best  = region_sz[k];
                r.worst = region_sz[k];
              end else begin
                if (region_sz[k] < r.best) r.best = region_sz[k];
                if (region_sz[k] > r.worst) r.worst = region_sz[k];
              end
            end
          end
          if (!found) r.st = ST_NOFIT;
        end
        default: ;
      endcase
      expected_fits.push_back(r);
    endfunction

    function void check_reply(fit_reply_t got);
      fit_reply_t want;
      if (expected_fits.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transfer: st %0d ff %h bf %h wf %h",
                   got.st, got.first, got.best, got.worst);
        return;
      end
      want = expected_fits.pop_front();
      if (got.st !== want.st || got.first !== want.first ||
          got.best !== want.best || got.worst !== want.worst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st %0d ff %h bf %h wf %h / got st %0d ff %h bf %h wf %h",
                   want.st, want.first, want.best, want.worst,
                   got.st, got.first, got.best, got.worst);
      end
    endfunction
  endclass

  bit   clk;
  logic rst_n;
  bit   hold_req;
  int   burst_left;
  int   items_sent;

  fit_scoreboard sb = new();

  fphs_in_if  in_ch();
  fphs_out_if out_ch();

  fit_policy_hole_search_unit #(
    .MAX_ENTRIES(TABLE_DEPTH),
    .SIZE_BITS  (FIELD_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin : result_monitor
    fit_reply_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.st    = status_t'(out_ch.status);
      got.first = out_ch.first_fit_size;
      got.best  = out_ch.best_fit_size;
      got.worst = out_ch.worst_fit_size;
      sb.check_reply(got);
    end
  end

  initial begin : receiver
    logic [15:0] pattern;
    int          stretch;
    out_ch.ready = 1'b0;
    pattern      = '1;
    stretch      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(16, 256);
        case ($urandom_range(0, 3))
          0: pattern = '1;
          1: pattern = 16'($urandom());
          2: pattern = 16'($urandom() & $urandom());
          default: pattern = 16'($urandom() & $urandom() & $urandom());
        endcase
        pattern[$urandom_range(0, 15)] = 1'b1;
      end
      stretch--;
      out_ch.ready = pattern[0];
      pattern      = {pattern[0], pattern[15:1]};
    end
  end

  task automatic send_item(input op_t op, input logic [KIND_W-1:0] kind,
                           input logic [FIELD_W-1:0] esz, input logic [FIELD_W-1:0] req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.entry_kind   = kind;
    in_ch.entry_size   = esz;
    in_ch.request_size = req;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.predict_fit(op, kind, esz, req);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    send_item(op_t'($urandom_range(0, 3)), KIND_W'($urandom()),
              FIELD_W'($urandom()), FIELD_W'($urandom()));
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (sb.expected_fits.size() != 0) @(negedge clk);
  endtask

  task automatic run_fit_sequence(input int seq_no);
    logic [FIELD_W-1:0] stored[$];
    logic [FIELD_W-1:0] sz;
    logic [FIELD_W-1:0] req;
    logic [KIND_W-1:0]  kind;
    int                 n_app;
    if (seq_no == 0 || $urandom_range(0, 3) != 0)
      send_item(OP_CLEAR, KIND_W'($urandom()), FIELD_W'($urandom()), FIELD_W'($urandom()));
    n_app = (seq_no == 0 || $urandom_range(0, 7) == 0) ?
            $urandom_range(30, 36) : $urandom_range(0, 12);
    repeat (n_app) begin
      case ($urandom_range(0, 3))
        1: sz = FIELD_W'($urandom_range(0, 15));
        2: case ($urandom_range(0, 5))
             0: sz = 16'h0000;
             1: sz = 16'h0001;
             2: sz = 16'h7fff;
             3: sz = 16'h8000;
             4: sz = 16'hfffe;
             default: sz = 16'hffff;
           endcase
        default: sz = FIELD_W'($urandom());
      endcase
      if (seq_no != 0 && $urandom_range(0, 9) == 0)
        kind = ($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3;
      else
        kind = ($urandom_range(0, 4) < 3) ? KIND_HOLE : KIND_BLOCK;
      stored.push_back(sz);
      send_item(OP_APPEND, kind, sz, FIELD_W'($urandom()));
    end
    repeat ($urandom_range(1, 6)) begin
      if (stored.size() == 0 || $urandom_range(0, 4) == 0) begin
        req = FIELD_W'($urandom());
      end else begin
        sz = stored[$urandom_range(0, stored.size() - 1)];
        case ($urandom_range(0, 5))
          0: req = sz + 1'b1;
          1: req = sz - 1'b1;
          2: req = '0;
          3: req = '1;
          default: req = sz;
        endcase
      end
      send_item(OP_QUERY, KIND_W'($urandom()), FIELD_W'($urandom()), req);
    end
  endtask

  initial begin : stimulus
    int seq_no;
    rst_n              = 1'b0;
    hold_req           = 1'b0;
    burst_left         = 0;
    items_sent         = 0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_CLEAR;
    in_ch.entry_kind   = '0;
    in_ch.entry_size   = '0;
    in_ch.request_size = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h0000);
    send_item(OP_NONE,   2'd3,       16'hffff, 16'hffff);
    send_item(OP_APPEND, 2'd0,       16'h1234, 16'h0000);
    send_item(OP_APPEND, 2'd3,       16'hffff, 16'hffff);
    send_item(OP_APPEND, KIND_BLOCK, 16'hffff, 16'h0000);
    send_item(OP_APPEND, KIND_HOLE,  16'h0000, 16'h0000);
    send_item(OP_QUERY,  2'd0,       16'h0000, 16'h0000);
    send_item(OP_QUERY,  2'd3,       16'hffff, 16'h0001);
    send_item(OP_APPEND, KIND_HOLE,  16'hffff, 16'hffff);
    send_item(OP_APPEND, KIND_HOLE,  16'h8000, 16'h0000);
    send_item(OP_APPEND, KIND_HOLE,  16'h8000, 16'h0000);
    send_item(OP_APPEND, KIND_HOLE,  16'h0001, 16'h0000);
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h8000);
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'hffff);
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h8001);
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h0000);
    send_item(OP_NONE, KIND_W'($urandom()), FIELD_W'($urandom()), FIELD_W'($urandom()));
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h0002);
    send_item(OP_CLEAR,  2'd3,       16'hffff, 16'hffff);
    send_item(OP_QUERY,  KIND_HOLE,  16'h0000, 16'h0000);
    send_item(OP_APPEND, KIND_HOLE,  16'h1234, 16'hffff);
    send_item(OP_QUERY,  2'd0,       16'hffff, 16'h1234);
    send_item(OP_QUERY,  2'd0,       16'hffff, 16'h1235);
    wait_drain();

    seq_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (seq_no == 10) begin
        // stall the output long enough for the input to back up
        hold_req   = 1'b1;
        burst_left = 1000;
        repeat (16) send_random_item();
        burst_left = 0;
        wait_drain();
      end
      if (seq_no != 0 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4))
          send_random_item();
      end else begin
        run_fit_sequence(seq_no);
      end
      if ($urandom_range(0, 15) == 0) wait_drain();
      seq_no++;
    end

    wait_drain();
    repeat (SETTLE) @(negedge clk);
    if (sb.expected_fits.size() != 0) begin
      sb.errors++;
      $display("%0d expected transfers never arrived", sb.expected_fits.size());
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
